// ----- design/isp_pkg.sv -----
// Package for the indexed symbol packetizer: payload structs, result bundle,
// constants and small helper functions. Depends on nothing.
package isp_pkg;

   localparam logic [15:0] SYMBOL_BYTES        = 16'd4;
   localparam logic [15:0] PAYLOAD_RESET       = 16'd64;
   localparam logic [9:0]  INDEX_LAST          = 10'd999;
   localparam logic [13:0] PACKET_LAST         = 14'd9999;

   localparam logic        KIND_SYMBOL         = 1'b0;
   localparam logic        KIND_CLOSE          = 1'b1;

   localparam int          CSR_ADDR_W          = 3;
   localparam logic        REG_PAYLOAD_BYTES   = 1'b0;

   localparam int          QUEUE_DEPTH         = 4;
   localparam int          QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] char_in;
      logic       first_of_line;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [13:0] packet_number;
      logic [9:0]  line_index;
      logic [7:0]  char_out;
      logic [13:0] symbol_count;
      logic [1:0]  pad_count;
      logic        last;
   } rsp_type;

   // Everything one input character produces: an optional close before the
   // symbol, the symbol itself, and an optional close after it.
   typedef struct packed {
      logic        pre_valid;
      logic [13:0] pre_packet;
      logic [13:0] pre_count;
      logic [1:0]  pre_pad;
      logic [13:0] sym_packet;
      logic [9:0]  sym_index;
      logic [7:0]  sym_char;
      logic        post_valid;
      logic [13:0] post_count;
   } bundle_type;

   function automatic logic [13:0] next_packet(input logic [13:0] pkt);
      next_packet = (pkt >= PACKET_LAST) ? 14'd0 : pkt + 14'd1;
   endfunction

endpackage

// ----- design/indexed_symbol_packetizer.sv -----
// Packetizer top: register port, packing core, result queue (isp_pkg, isp_core, isp_queue).
// A character's bundle is registered into the queue; its first result is offered once older bundles have drained.
// Throughput: one character per cycle while each gives one result and rsp_ready is high; the
// result port moves one result per cycle, extra close results wait in the four-bundle queue of
// isp_queue, and req_ready drops only while that queue is full.
// Reset (synchronous, active high) empties the queue, clears packing state, payload_bytes = 64.
module indexed_symbol_packetizer (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  isp_pkg::req_type                   req_data,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output isp_pkg::rsp_type                   rsp_data,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [isp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   // The only register, payload_bytes, sits at byte address zero. Address bit
   // two selects the register slot; slots beyond the list read as zero and
   // ignore writes.
   logic [15:0] payload_ff, payload_in;
   logic        csr_write;
   logic        csr_hit;

   // A character transfer happens whenever the queue has room for its bundle.
   logic                 req_accept;
   logic                 queue_room;
   isp_pkg::bundle_type  bundle;

   always_comb begin
      pready     = 1'b1;
      csr_hit    = paddr[2] == isp_pkg::REG_PAYLOAD_BYTES;
      csr_write  = psel && penable && pwrite && pready;
      payload_in = (csr_write && csr_hit) ? pwdata[15:0] : payload_ff;
      prdata     = csr_hit ? {16'd0, payload_ff} : 32'd0;

      req_ready  = queue_room;
      req_accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff <= isp_pkg::PAYLOAD_RESET;
      end else begin
         payload_ff <= payload_in;
      end
   end

   // The core works out all results of the character in the transfer cycle and
   // advances the packet, byte, symbol and line counters at the same edge.
   isp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .payload_bytes (payload_ff),
      .accept        (req_accept),
      .req           (req_data),
      .bundle        (bundle)
   );

   // The queue stores each bundle and emits its one to three results in order,
   // flagging the final one with last.
   isp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (req_accept),
      .push_bundle (bundle),
      .has_room    (queue_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- design/isp_core.sv -----
// Packing state and result formation for one character per cycle.
// Depends on isp_pkg.
module isp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         payload_bytes,
   input  logic                accept,
   input  isp_pkg::req_type    req,
   output isp_pkg::bundle_type bundle
);

   logic [15:0] bytes_used_ff, bytes_used_in;
   logic [13:0] packet_count_ff, packet_count_in;
   logic [13:0] symbols_ff, symbols_in;
   logic [9:0]  line_index_ff, line_index_in;

   logic [15:0] cap;
   logic [16:0] need;
   logic        pre_close;
   logic [15:0] room;
   logic [13:0] pkt_sym;
   logic [15:0] used_sym;
   logic [13:0] syms_sym;
   logic        post_close;
   logic [9:0]  idx;

   always_comb begin
      cap       = (payload_bytes < isp_pkg::SYMBOL_BYTES) ? isp_pkg::SYMBOL_BYTES
                                                          : payload_bytes;
      need      = {1'b0, bytes_used_ff} + {1'b0, isp_pkg::SYMBOL_BYTES};
      pre_close = need > {1'b0, cap};
      room      = (bytes_used_ff < cap) ? cap - bytes_used_ff : 16'd0;

      pkt_sym   = pre_close ? isp_pkg::next_packet(packet_count_ff) : packet_count_ff;
      used_sym  = (pre_close ? 16'd0 : bytes_used_ff) + isp_pkg::SYMBOL_BYTES;
      syms_sym  = (pre_close ? 14'd0 : symbols_ff) + 14'd1;
      post_close = used_sym == cap;

      idx = req.first_of_line ? 10'd0 : line_index_ff;
      if (idx > isp_pkg::INDEX_LAST) begin
         idx = 10'd0;
      end

      bundle.pre_valid  = pre_close;
      bundle.pre_packet = packet_count_ff;
      bundle.pre_count  = symbols_ff;
      bundle.pre_pad    = room[1:0];
      bundle.sym_packet = pkt_sym;
      bundle.sym_index  = idx;
      bundle.sym_char   = req.char_in;
      bundle.post_valid = post_close;
      bundle.post_count = syms_sym;

      line_index_in   = (idx >= isp_pkg::INDEX_LAST) ? 10'd0 : idx + 10'd1;
      bytes_used_in   = post_close ? 16'd0 : used_sym;
      symbols_in      = post_close ? 14'd0 : syms_sym;
      packet_count_in = post_close ? isp_pkg::next_packet(pkt_sym) : pkt_sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_used_ff   <= '0;
         packet_count_ff <= '0;
         symbols_ff      <= '0;
         line_index_ff   <= '0;
      end else if (accept) begin
         bytes_used_ff   <= bytes_used_in;
         packet_count_ff <= packet_count_in;
         symbols_ff      <= symbols_in;
         line_index_ff   <= line_index_in;
      end
   end

endmodule

// ----- design/isp_queue.sv -----
// Small queue of result bundles and the unpacker that hands out their
// results one transfer at a time. Depends on isp_pkg.
module isp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  isp_pkg::bundle_type push_bundle,
   output logic                has_room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output isp_pkg::rsp_type    rsp_data
);

   localparam int PW = isp_pkg::QUEUE_PTR_W;

   isp_pkg::bundle_type entry_ff [isp_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          pre_done_ff, pre_done_in;
   logic          sym_done_ff, sym_done_in;

   isp_pkg::bundle_type head;
   logic                 pop;
   logic                 is_pre;
   logic                 is_sym;

   always_comb begin
      head      = entry_ff[rd_ptr_ff];
      has_room  = count_ff != (PW + 1)'(isp_pkg::QUEUE_DEPTH);
      rsp_valid = count_ff != '0;

      is_pre = head.pre_valid && !pre_done_ff;
      is_sym = !is_pre && !sym_done_ff;

      rsp_data = '0;
      priority if (is_pre) begin
         rsp_data.kind          = isp_pkg::KIND_CLOSE;
         rsp_data.packet_number = head.pre_packet;
         rsp_data.symbol_count  = head.pre_count;
         rsp_data.pad_count     = head.pre_pad;
         rsp_data.last          = 1'b0;
      end else if (is_sym) begin
         rsp_data.kind          = isp_pkg::KIND_SYMBOL;
         rsp_data.packet_number = head.sym_packet;
         rsp_data.line_index    = head.sym_index;
         rsp_data.char_out      = head.sym_char;
         rsp_data.last          = !head.post_valid;
      end else begin
         // The closing packet is the one the symbol was just placed in.
         rsp_data.kind          = isp_pkg::KIND_CLOSE;
         rsp_data.packet_number = head.sym_packet;
         rsp_data.symbol_count  = head.post_count;
         rsp_data.last          = 1'b1;
      end

      pop         = rsp_valid && rsp_ready && rsp_data.last;
      pre_done_in = pre_done_ff;
      sym_done_in = sym_done_ff;
      if (pop) begin
         pre_done_in = 1'b0;
         sym_done_in = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (is_pre) begin
            pre_done_in = 1'b1;
         end else begin
            sym_done_in = 1'b1;
         end
      end

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW + 1)'(push) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         pre_done_ff <= 1'b0;
         sym_done_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         pre_done_ff <= pre_done_in;
         sym_done_ff <= sym_done_in;
      end
   end

endmodule
